### hdl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg: shared types and constants of the lowest free slot allocator
// Beat structs for the request and result channels, cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

  // Defaults for the top level parameters
  localparam int unsigned SlotsDef    = 64;
  localparam int unsigned TimeBitsDef = 17;

  // Fixed field widths of the channel beats
  localparam int unsigned FieldTimeW = 17;
  localparam int unsigned SlotW      = 6;

  typedef struct packed {
    logic                  new_session;
    logic [FieldTimeW-1:0] arrival_time;
    logic [FieldTimeW-1:0] leave_time;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             is_target;
    logic             full_res;
  } res_t;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    logic clear;   // drop every hold (new session)
    logic rel_en;  // drop holds whose release time is due
  } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/lfsa_cell.sv
// ----------------------------------------------------------------------------
// lfsa_cell: one slot of the allocator chain
// Holds the slot's busy bit and release time, claims the search token when
// free and otherwise passes it to the next cell in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_cell #(
  parameter int unsigned TIME_BITS = lfsa_pkg::TimeBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lfsa_pkg::cell_ctl_t  ctl_i,
  input  wire logic [TIME_BITS-1:0] arrival_i,
  input  wire logic [TIME_BITS-1:0] leave_i,
  input  wire logic                 tok_i,
  output logic                      tok_o,
  output logic                      claim_o
);
  import lfsa_pkg::*;

  logic                 held_q, held_d;
  logic                 pass_q, pass_d;
  logic [TIME_BITS-1:0] rel_time_q;
  logic                 due;

  assign due     = (rel_time_q <= arrival_i);
  assign claim_o = tok_i & ~held_q;
  assign tok_o   = pass_q;

  always_comb begin
    held_d = held_q;
    if (ctl_i.clear) begin
      held_d = 1'b0;
    end else if (ctl_i.rel_en && held_q && due) begin
      held_d = 1'b0;
    end else if (claim_o) begin
      held_d = 1'b1;
    end
    pass_d = tok_i & held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  // Release time: written on claim only, read only while held
  always_ff @(posedge clk_i) begin
    if (claim_o) begin
      rel_time_q <= leave_i;
    end
  end

endmodule

`default_nettype wire

### hdl/lowest_free_slot_allocator_core.sv
// Sequence: an accepted request passes the release step, then the search token
//   walks one cell per cycle from slot 0 until a free slot claims it or it falls
//   off the end (full result), so a higher slot or a full chain means a longer search.
// Requests: one request in flight; in_ready_o stays low from acceptance until the
//   finish step hands the result to the output register, held off by a stalled output.
// Reset: asynchronous, active low; all slots free, target_arrival = 0.
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_core: lowest free slot allocator, timed release
// Chain of slot cells; clears all holds (new session) or releases due holds in
// parallel, then walks a token from slot 0 upward and grants the first free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_slot_allocator_core #(
  parameter int unsigned SLOTS     = lfsa_pkg::SlotsDef,
  parameter int unsigned TIME_BITS = lfsa_pkg::TimeBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration: target_arrival register
  input  wire logic                            cfg_we_i,
  input  wire logic [lfsa_pkg::FieldTimeW-1:0] cfg_data_i,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lfsa_pkg::req_t                  in_data_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lfsa_pkg::res_t                       out_data_o
);
  import lfsa_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,   // wait for a request beat
    ST_REL,    // clear / release due holds in every cell
    ST_SRCH,   // token walks the chain looking for a free cell
    ST_FIN     // hand the result to the output register
  } state_e;

  state_e               state_q, state_d;
  logic [FieldTimeW-1:0] target_q;
  logic                 new_sess_q;
  logic [TIME_BITS-1:0] arrival_q;
  logic [TIME_BITS-1:0] leave_q;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 start_q;
  res_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q, out_d;

  cell_ctl_t            cell_ctl;
  logic [SLOTS-1:0]     pass;
  logic [SLOTS-1:0]     claim;
  logic                 hit;
  logic                 last_pass;
  logic                 accept;
  logic                 out_free;
  logic                 tgt_match;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  // Broadcast control: only during the release step
  assign cell_ctl.clear  = (state_q == ST_REL) & new_sess_q;
  assign cell_ctl.rel_en = (state_q == ST_REL);

  // ---------------------------------------------------------------------
  // Cell chain: token enters cell 0 after the release step and moves up
  // one cell per cycle until a free cell claims it.
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic tok_in;
    if (g == 0) begin : g_head
      assign tok_in = start_q;
    end else begin : g_link
      assign tok_in = pass[g-1];
    end
    lfsa_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (cell_ctl),
      .arrival_i (arrival_q),
      .leave_i   (leave_q),
      .tok_i     (tok_in),
      .tok_o     (pass[g]),
      .claim_o   (claim[g])
    );
  end

  assign hit       = |claim;
  assign last_pass = pass[SLOTS-1];
  assign tgt_match = (arrival_q == TIME_BITS'(target_q));

  // ---------------------------------------------------------------------
  // Sequencer: idx tracks the token position during the search.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          state_d = ST_REL;
        end
      end
      ST_REL: begin
        state_d = ST_SRCH;
      end
      ST_SRCH: begin
        if (hit) begin
          res_d.slot      = SlotW'(idx_q);
          res_d.is_target = tgt_match;
          res_d.full_res  = 1'b0;
          state_d         = ST_FIN;
        end else if (last_pass) begin
          // token fell off the end: every slot held
          res_d.slot      = '0;
          res_d.is_target = 1'b0;
          res_d.full_res  = 1'b1;
          state_d         = ST_FIN;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_FIN: begin
        // hold here until the output register frees up
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      start_q     <= (state_q == ST_REL);
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: request capture, pending result, output beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_sess_q <= in_data_i.new_session;
      arrival_q  <= TIME_BITS'(in_data_i.arrival_time);
      leave_q    <= TIME_BITS'(in_data_i.leave_time);
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Only one token lives in the chain, so at most one cell claims.
  a_one_claim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(claim))
    else $error("more than one cell claimed the token");

  // A claim and a token leaving the last cell never coincide.
  a_hit_or_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit && last_pass))
    else $error("grant and full seen together");

  // Token only travels during the search.
  a_tok_in_srch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|pass || start_q) |-> (state_q == ST_SRCH))
    else $error("search token outside search state");

  // An accepted request enters the release step next.
  a_acc_rel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_REL))
    else $error("accepted request skipped release step");

  // A new result beat is only produced from the finish step.
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result beat raised outside finish step");

endmodule

`default_nettype wire

### tb/tb_lowest_free_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_lowest_free_slot_allocator_core: self-checking bench of the slot allocator
// Drives request beats through valid/ready with random bursts and gaps, grants
// slots in a local copy of the allocator state and compares each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lowest_free_slot_allocator_core;

  import lfsa_pkg::*;

  localparam int unsigned SLOTS       = SlotsDef;
  localparam int unsigned TIME_MAX    = (1 << FieldTimeW) - 1;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 600_000;

  // Receiver stall patterns, each kept for a random window of cycles
  typedef enum int unsigned {
    RX_OPEN,   // always ready
    RX_LIGHT,  // ready with a probability of three in four
    RX_HALF,   // coin flip every cycle
    RX_CHOKE   // short ready bursts between long stalls
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i   = 1'b0;
  logic [FieldTimeW-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  req_t                  in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  res_t                  out_data_o;

  // Local copy of the allocator: hold flags, release times, target register
  bit                    slot_held    [SLOTS];
  logic [FieldTimeW-1:0] slot_release [SLOTS];
  logic [FieldTimeW-1:0] target_reg = '0;

  res_t        grant_q [$];   // grants still owed by the block, oldest first
  res_t        want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Sender burst state
  int unsigned tx_burst_left = 0;
  bit          tx_gapless    = 1'b0;

  // Receiver state; hold_reqs is bumped by a test to ask for a long hold-off
  int unsigned hold_reqs   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_window   = 0;
  rx_mode_e    rx_mode     = RX_OPEN;

  lowest_free_slot_allocator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d grants pending", $time, cycle_count,
               grant_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Grant a slot for one request beat and advance the local allocator state.
  // New session drops every hold first, then due holds are released, then the
  // lowest free slot is taken.
  function automatic res_t grant_slot(input req_t r);
    res_t res;
    int   pick;
    int   i;
    pick = -1;
    res  = '0;
    if (r.new_session) begin
      foreach (slot_held[k]) slot_held[k] = 1'b0;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (slot_held[i] && slot_release[i] <= r.arrival_time) slot_held[i] = 1'b0;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (!slot_held[i] && pick < 0) pick = i;
    end
    if (pick < 0) begin
      res.full_res = 1'b1;
    end else begin
      slot_held[pick]    = 1'b1;
      slot_release[pick] = r.leave_time;
      res.slot           = pick[SlotW-1:0];
      res.is_target      = (r.arrival_time == target_reg);
    end
    return res;
  endfunction

  function automatic req_t make_req(input bit ns, input int unsigned arr,
                                    input int unsigned lv);
    req_t r;
    r.new_session  = ns;
    r.arrival_time = FieldTimeW'(arr);
    r.leave_time   = FieldTimeW'(lv);
    return r;
  endfunction

  // Offer one request beat and hold it until accepted. Valid stays high on
  // return so that a following beat can go out back to back; anything else
  // that spends time drops valid first.
  task automatic send_request(input req_t r);
    if (!tx_gapless && tx_burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      tx_burst_left = $urandom_range(1, 24);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    grant_q.push_back(grant_slot(r));
  endtask

  // Drop valid and wait until every owed grant has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (grant_q.size() != 0);
  endtask

  // Write the target register while the block is idle.
  task automatic write_target(input logic [FieldTimeW-1:0] v);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    target_reg = v;
  endtask

  // Release at exact boundary, leave time before arrival, arrivals out of
  // order, new session clearing holds.
  task automatic test_release_rules();
    write_target('0);
    send_request(make_req(0, 0, 0));          // slot 0, flagged (target 0)
    send_request(make_req(0, 0, TIME_MAX));   // slot 0 due at once, taken again
    send_request(make_req(0, 5, 10));         // slot 1
    send_request(make_req(0, 10, 20));        // slot 1 due exactly at 10
    send_request(make_req(0, 9, 3));          // arrival goes back: slot 2
    send_request(make_req(0, 9, 100));        // slot 2 left before 9: reuse
    send_request(make_req(1, 50, 60));        // new session: slot 0
    send_request(make_req(0, 50, 40));        // slot 1, leaves before arrival
    send_request(make_req(0, 60, 70));        // both due: slot 0
  endtask

  // Target flag at the top of the time range, plus alternating bit patterns.
  task automatic test_target_extremes();
    write_target(FieldTimeW'(TIME_MAX));
    send_request(make_req(0, TIME_MAX, TIME_MAX));
    send_request(make_req(0, TIME_MAX, 0));
    send_request(make_req(0, TIME_MAX - 1, 5));
    send_request(make_req(1, TIME_MAX, TIME_MAX));
    send_request(make_req(0, 'h15555, 'h0AAAA));
    send_request(make_req(1, 'h0AAAA, 'h15555));
    write_target(FieldTimeW'('h0AAAA));
    send_request(make_req(0, 'h0AAAA, 'h1FFFF));
    send_request(make_req(0, 'h15555, 'h00001));
  endtask

  // Fill every slot with long holds while the receiver holds off, so the
  // single request in flight backs up the input. The last beats find no
  // free slot and carry the target arrival, which must not be flagged.
  task automatic test_fill_under_backpressure();
    int unsigned i;
    write_target(FieldTimeW'(108));
    tx_gapless = 1'b1;
    hold_reqs <= hold_reqs + 1;
    for (i = 0; i < SLOTS + 6; i++) begin
      send_request(make_req(i == 0, 100 + i / 8, TIME_MAX));
    end
    send_request(make_req(0, TIME_MAX, 3));   // everything due: slot 0
    tx_gapless = 1'b0;
  endtask

  // Sessions of ascending arrivals with random spacing and hold lengths,
  // mixed with free-form noise beats. Each phase uses its own target.
  task automatic test_random_traffic();
    int unsigned           ph;
    int unsigned           n;
    int unsigned           k;
    int unsigned           len;
    int unsigned           arr;
    int unsigned           step_max;
    int unsigned           dur_max;
    logic [FieldTimeW-1:0] tgt;
    req_t                  r;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          tgt = '0;
        end
        1: begin
          tgt = FieldTimeW'(TIME_MAX);
        end
        default: begin
          tgt = FieldTimeW'($urandom_range(0, TIME_MAX));
        end
      endcase
      write_target(tgt);
      n = 0;
      while (n < 100) begin
        case ($urandom_range(0, 4))
          0: step_max = 0;
          1: step_max = 1;
          2: step_max = 3;
          3: step_max = 20;
          default: step_max = 200;
        endcase
        case ($urandom_range(0, 4))
          0: dur_max = 2;
          1: dur_max = 64;
          2: dur_max = 300;
          3: dur_max = 5000;
          default: dur_max = TIME_MAX;
        endcase
        // Start most sessions just below the target so the flag gets hit.
        if ($urandom_range(0, 2) == 0) arr = $urandom_range(0, TIME_MAX);
        else arr = (tgt > 40) ? tgt - $urandom_range(0, 40) : 0;
        len = $urandom_range(10, 90);
        for (k = 0; k < len && n < 100; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            // noise: any field values, arrival order ignored
            r.new_session  = 1'($urandom_range(0, 1));
            r.arrival_time = FieldTimeW'($urandom_range(0, TIME_MAX));
            r.leave_time   = FieldTimeW'($urandom_range(0, TIME_MAX));
          end else begin
            r.new_session  = (k == 0) ? ($urandom_range(0, 7) != 0)
                                      : ($urandom_range(0, 63) == 0);
            r.arrival_time = FieldTimeW'(arr);
            if ($urandom_range(0, 15) == 0)
              r.leave_time = FieldTimeW'(arr - $urandom_range(0, 200));
            else
              r.leave_time = FieldTimeW'(arr + $urandom_range(0, dur_max));
            arr = arr + $urandom_range(0, step_max);
            if (arr > TIME_MAX) arr = TIME_MAX;
          end
          send_request(r);
          n++;
        end
      end
    end
  endtask

  // Result side: check every accepted beat against the oldest owed grant,
  // then pick the ready level for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_q.size() == 0) begin
        $display("%0t: result beat with no grant owed, got %p", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = grant_q.pop_front();
        if (out_data_o.slot !== want.slot) begin
          $display("%0t: slot expected %0d, got %0d", $time, want.slot, out_data_o.slot);
          mismatch_count++;
        end
        if (out_data_o.is_target !== want.is_target) begin
          $display("%0t: is_target expected %0b, got %0b", $time, want.is_target,
                   out_data_o.is_target);
          mismatch_count++;
        end
        if (out_data_o.full_res !== want.full_res) begin
          $display("%0t: full_res expected %0b, got %0b", $time, want.full_res,
                   out_data_o.full_res);
          mismatch_count++;
        end
      end
    end

    // A fresh hold-off request wins over the running pattern.
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_window == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        rx_window = $urandom_range(8, 160);
      end
      rx_window--;
      case (rx_mode)
        RX_OPEN: begin
          out_ready_i <= 1'b1;
        end
        RX_LIGHT: begin
          out_ready_i <= ($urandom_range(0, 3) != 0);
        end
        RX_HALF: begin
          out_ready_i <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          out_ready_i <= ((rx_window % 12) < 3);
        end
      endcase
    end
  end

  // Test sequence: reset once, run each test, drain, then report.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_release_rules();
    test_target_extremes();
    test_fill_under_backpressure();
    test_random_traffic();

    // Let the last grants come back, then watch a little longer for strays.
    drain_results();
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
